/* hw/rtl/bessy_pkg.sv */
// bessy_pkg: types, constants and coefficient tables for the Bessel Y0/Y1 pipeline.
// No dependencies; used by bessel_y0_y1_chebyshev_top.
`default_nettype none

package bessy_pkg;

	localparam int DEF_NUM_TERMS     = 18;
	localparam int DEF_OUT_FRAC_BITS = 24;
	localparam int SERIES_LEN        = 18;

	localparam longint unsigned DEC_ONE = 64'd1000000000000000000;

	// coefficients in units of 1e-18
	localparam longint EVEN_DEC [SERIES_LEN] = '{
		-64'sd21505111449657551, -64'sd275118133043518791, 64'sd198605634702554156,
		64'sd234252746109021802, -64'sd165635981713650413, 64'sd44621379540669282,
		-64'sd6932286291523188, 64'sd719117403752303, -64'sd53925079722939,
		64'sd3076493288108, -64'sd138457181230, 64'sd5051054369,
		-64'sd152582850, 64'sd3882867, -64'sd84429,
		64'sd1587, -64'sd26, 64'sd0
	};

	localparam longint ODD_DEC [SERIES_LEN] = '{
		-64'sd40172946544414076, -64'sd444447147630558063, -64'sd22719244428417736,
		64'sd206644541017490520, -64'sd86671697056948524, 64'sd17636703003163134,
		-64'sd2235619294485095, 64'sd197062302701541, -64'sd12885853299241,
		64'sd652847952359, -64'sd26450737175, 64'sd878030117,
		-64'sd24343279, 64'sd572612, -64'sd11578,
		64'sd203, -64'sd3, 64'sd0
	};

	localparam longint DEC_K_LOG   = 64'sd441271200305303000; // 2 ln2 / pi
	localparam longint DEC_K_EULER = 64'sd367466863879016400; // (2/pi) C
	localparam longint DEC_TWO_PI  = 64'sd636619772367581343; // 2 / pi

	// decimal fraction (1e-18 units) to fixed point, round half away from zero
	function automatic longint dec_to_fixed(longint d, int unsigned bits);
		logic neg;
		longint unsigned rem;
		longint unsigned q;
		neg = (d < 0);
		rem = neg ? longint'(-d) : d;
		q = 64'd0;
		for (int unsigned i = 0; i <= bits; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= DEC_ONE) begin
				rem = rem - DEC_ONE;
				q = q | 64'd1;
			end
		end
		q = (q + 64'd1) >> 1;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	localparam logic signed [31:0] K_LOG_Q30   = 32'(dec_to_fixed(DEC_K_LOG, 30));
	localparam logic signed [35:0] K_EULER_Q28 = 36'(dec_to_fixed(DEC_K_EULER, 28));
	localparam logic [62:0]        K_TWO_PI_Q60 = 63'(dec_to_fixed(DEC_TWO_PI, 60));

	localparam int LOG_STEPS  = 28;
	localparam int DIV_BITS   = 63;
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

	typedef struct packed {
		logic               op;
		logic               dom;
		logic [30:0]        x;
		logic signed [31:0] j;
		logic signed [31:0] w;
		logic signed [33:0] cur;
		logic signed [33:0] prev;
		logic signed [63:0] acc;
		logic [30:0]        m;
		logic [4:0]         p;
		logic [27:0]        frac;
		logic [31:0]        rem;
		logic [62:0]        num;
		logic [62:0]        quo;
		logic signed [35:0] a;
		logic signed [63:0] term;
		logic [31:0]        y;
		logic               sat;
	} pipe_t;

endpackage

`default_nettype wire

/* hw/rtl/bessel_y0_y1_chebyshev_top.sv */
// bessel_y0_y1_chebyshev_top: pipelined Y0/Y1 evaluator for 0 < x < 8.
// Depends on bessy_pkg (types, coefficient tables, fixed-point constants).
//
//  channel | signals                              | width     | dir
//  --------+--------------------------------------+-----------+----
//  in      | in_valid in_ready op x j_value       | 1,31,32   | in
//  out     | out_valid out_ready y saturated      | 32,1,1    | out
//          | domain_error                         |           |
//
// One item enters per cycle unless a stalled output backs up to stage 0.
// The depth is set by the 28 squaring steps of the log2 unit, one per stage; the
// Chebyshev recurrence and the 3-bit-per-stage divider run alongside in the same stages.
// Each stage holds a valid bit and advances when it is empty or the next one advances,
// so bubbles close up and a stalled output holds its item without loss or repeat.
// Reset clears only the valid bits.
`default_nettype none

module bessel_y0_y1_chebyshev_top #(
	parameter int NUM_TERMS     = bessy_pkg::DEF_NUM_TERMS,
	parameter int OUT_FRAC_BITS = bessy_pkg::DEF_OUT_FRAC_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [30:0] x,
	input  wire logic signed [31:0] j_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] y,
	output logic             saturated,
	output logic             domain_error
);
	import bessy_pkg::*;

	localparam int NI = LOG_STEPS;   // iteration stages
	localparam int SA = NI + 1;      // log scale
	localparam int SB = NI + 2;      // A*J term
	localparam int SC = NI + 3;      // final sum
	localparam int SD = NI + 4;      // round and clamp
	localparam int NS = NI + 5;
	localparam int SH = 32 - OUT_FRAC_BITS;
	localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);

	pipe_t        pl_s [NS];
	pipe_t        nx   [NS];
	logic [NS-1:0] v_s;
	logic [NS-1:0] vin;
	logic [NS:0]   en;

	// stage advance chain
	assign en[NS] = out_ready;
	assign vin[0] = in_valid;
	for (genvar k = 0; k < NS; k++) begin : g_ctl
		assign en[k] = !v_s[k] || en[k+1];
		if (k > 0) begin : g_vin
			assign vin[k] = v_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vin[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				pl_s[k] <= nx[k];
			end
		end
	end
	assign in_ready = en[0];

	// entry: w = 2z^2-1, leading one, normalized mantissa, divider numerator
	logic [61:0]        xsq;
	logic signed [31:0] w0;
	logic [4:0]         p0;
	logic signed [33:0] z0;
	assign xsq = x * x;
	assign w0  = $signed({1'b0, xsq[61:31]}) - 32'sd1073741824;
	assign z0  = $signed({4'b0, x[30:1]});

	always_comb begin
		p0 = 5'd0;
		for (int b = 0; b < 31; b++) begin
			if (x[b]) begin
				p0 = 5'(b);
			end
		end
	end

	always_comb begin
		nx[0]      = '0;
		nx[0].op   = op;
		nx[0].dom  = (x == 31'd0);
		nx[0].x    = x;
		nx[0].j    = j_value;
		nx[0].w    = w0;
		nx[0].cur  = op ? z0 : 34'sd1073741824;
		nx[0].prev = op ? z0 : 34'(w0);
		nx[0].m    = 31'(x << (5'd30 - p0));
		nx[0].p    = p0;
		nx[0].num  = K_TWO_PI_Q60 + 63'(x[30:1]);
	end

	// iteration stages: series term, recurrence step, log squaring, divider bits
	for (genvar i = 0; i < NI; i++) begin : g_it
		logic signed [63:0] acc_n;
		logic signed [33:0] cur_n;
		logic signed [33:0] prev_n;
		logic [30:0]        m_n;
		logic [27:0]        frac_n;
		logic [31:0]        rem_n;
		logic [62:0]        num_n;
		logic [62:0]        quo_n;
		logic [61:0]        sq;
		logic [31:0]        mm;

		if (i < NUM_TERMS) begin : g_cheb
			localparam longint CE = dec_to_fixed(EVEN_DEC[i], 32);
			localparam longint CO = dec_to_fixed(ODD_DEC[i], 32);
			logic signed [32:0] coef;
			logic signed [33:0] cur_c;
			logic signed [31:0] w_c;
			logic signed [66:0] pc;
			logic signed [65:0] pw;
			assign cur_c  = pl_s[i].cur;
			assign w_c    = pl_s[i].w;
			assign coef   = pl_s[i].op ? 33'(CO) : 33'(CE);
			assign pc     = coef * cur_c;
			assign pw     = w_c * cur_c;
			assign acc_n  = pl_s[i].acc + 64'(pc >>> 30);
			assign cur_n  = 34'(pw >>> 29) - pl_s[i].prev;
			assign prev_n = cur_c;
		end else begin : g_nocheb
			assign acc_n  = pl_s[i].acc;
			assign cur_n  = pl_s[i].cur;
			assign prev_n = pl_s[i].prev;
		end

		assign sq     = pl_s[i].m * pl_s[i].m;
		assign mm     = sq[61:30];
		assign m_n    = mm[31] ? mm[31:1] : mm[30:0];
		assign frac_n = {pl_s[i].frac[26:0], mm[31]};

		if (i < DIV_STAGES) begin : g_div
			always_comb begin
				rem_n = pl_s[i].rem;
				num_n = pl_s[i].num;
				quo_n = pl_s[i].quo;
				for (int b = 0; b < DIV_STEP; b++) begin
					rem_n = {rem_n[30:0], num_n[62]};
					num_n = num_n << 1;
					if (rem_n >= {1'b0, pl_s[i].x}) begin
						rem_n = rem_n - {1'b0, pl_s[i].x};
						quo_n = {quo_n[61:0], 1'b1};
					end else begin
						quo_n = {quo_n[61:0], 1'b0};
					end
				end
			end
		end else begin : g_nodiv
			assign rem_n = pl_s[i].rem;
			assign num_n = pl_s[i].num;
			assign quo_n = pl_s[i].quo;
		end

		always_comb begin
			nx[i+1]      = pl_s[i];
			nx[i+1].acc  = acc_n;
			nx[i+1].cur  = cur_n;
			nx[i+1].prev = prev_n;
			nx[i+1].m    = m_n;
			nx[i+1].frac = frac_n;
			nx[i+1].rem  = rem_n;
			nx[i+1].num  = num_n;
			nx[i+1].quo  = quo_n;
		end
	end

	// A = (2ln2/pi) log2(x/2) + (2/pi)C, Q.28
	logic signed [34:0] lg;
	logic signed [66:0] pk;
	assign lg = ((35'($signed({1'b0, pl_s[NI].p})) - 35'sd29) <<< 28)
		+ 35'($signed({1'b0, pl_s[NI].frac}));
	assign pk = K_LOG_Q30 * lg;
	always_comb begin
		nx[SA]   = pl_s[NI];
		nx[SA].a = 36'(pk >>> 30) + K_EULER_Q28;
	end

	// A*J in Q.32
	logic signed [35:0] a_c;
	logic signed [31:0] j_c;
	logic signed [67:0] pj;
	assign a_c = pl_s[SA].a;
	assign j_c = pl_s[SA].j;
	assign pj  = a_c * j_c;
	always_comb begin
		nx[SB]      = pl_s[SA];
		nx[SB].term = 64'(pj >>> 26);
	end

	// sum, minus 2/(pi x) for order 1
	always_comb begin
		nx[SC]     = pl_s[SB];
		nx[SC].acc = pl_s[SB].acc + pl_s[SB].term
			- (pl_s[SB].op ? 64'(pl_s[SB].quo) : 64'd0);
	end

	// round to output format and clamp
	logic signed [63:0] acc_c;
	logic signed [63:0] rnd;
	logic signed [63:0] r;
	assign acc_c = pl_s[SC].acc;
	assign rnd   = acc_c + HALF;
	assign r     = rnd >>> SH;
	always_comb begin
		nx[SD] = pl_s[SC];
		if (pl_s[SC].dom) begin
			nx[SD].y   = 32'd0;
			nx[SD].sat = 1'b0;
		end else if (r > 64'sd2147483647) begin
			nx[SD].y   = 32'h7FFF_FFFF;
			nx[SD].sat = 1'b1;
		end else if (r < -64'sd2147483648) begin
			nx[SD].y   = 32'h8000_0000;
			nx[SD].sat = 1'b1;
		end else begin
			nx[SD].y   = r[31:0];
			nx[SD].sat = 1'b0;
		end
	end

	assign out_valid    = v_s[SD];
	assign y            = pl_s[SD].y;
	assign saturated    = pl_s[SD].sat;
	assign domain_error = pl_s[SD].dom;

endmodule

`default_nettype wire
